// ===== sv/hbct_pkg.sv =====
// Package for the hit-box collision table: payload types, codes and tag decode.
// No dependencies.
package hbct_pkg;

  localparam int TableDepthDef = 256;
  localparam int StageDepthDef = 64;
  localparam int ColorsDef     = 16;

  localparam logic [6:0] GlyphFirst  = 7'd33;
  localparam logic [6:0] GlyphSplit  = 7'd97;
  localparam logic [6:0] GlyphLast   = 7'd126;
  localparam logic [6:0] LetterFirst = 7'd97;
  localparam logic [6:0] LetterLast  = 7'd122;

  typedef enum logic [2:0] {
    ActClear  = 3'd0,
    ActQuery  = 3'd1,
    ActAdd    = 3'd2,
    ActStage  = 3'd3,
    ActCommit = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    KindRect   = 2'd0,
    KindGlyph  = 2'd1,
    KindSprite = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StCommit,
    StOut
  } state_e;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic signed [15:0] box_w;
    logic signed [15:0] box_h;
    logic [1:0]         tag_kind;
    logic [6:0]         tag_index;
  } in_t;

  typedef struct packed {
    logic [15:0] rect_hits;
    logic [63:0] text_hits_low;
    logic [29:0] text_hits_high;
    logic [25:0] sprite_hits;
    logic [8:0]  stored_count;
    logic        overflow;
  } out_t;

  // One stored box: position, extent and tag.
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [1:0]  kind;
    logic [6:0]  idx;
  } box_t;

  // Hit masks accumulated along the chain.
  typedef struct packed {
    logic [15:0] rect;
    logic [63:0] tlow;
    logic [29:0] thigh;
    logic [25:0] spr;
  } hits_t;

endpackage

// ===== sv/hit_box_collision_table_core.sv =====
// Hit-box collision table: a rotating chain of box cells plus a staging
// chain. A query rotates the table chain once past the tail compare, a commit
// makes one pass of the staging chain, and other actions go straight to the
// result. Input waits for the result, so no new item is taken until the
// result of the last one has been taken.
// Reset empties both chains and clears the overflow flag.
module hit_box_collision_table_core import hbct_pkg::*; #(
  parameter int TableDepth = TableDepthDef,
  parameter int StageDepth = StageDepthDef,
  parameter int Colors     = ColorsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int TW = $clog2(TableDepth + 1);
  localparam int SW = $clog2(StageDepth + 1);
  localparam int RW = (TableDepth > StageDepth) ? TableDepth : StageDepth;
  localparam int CW = $clog2(RW + 1);

  state_e state_q, state_d;
  in_t    cmd_q;
  box_t   query_q, in_box;
  logic [TW-1:0] fill_q, fill_d;
  logic [SW-1:0] sfill_q, sfill_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic   ovf_q, ovf_d;
  hits_t  hits_q, hits_d;

  logic   tshift, sshift, tin_valid, sin_valid, clr;
  box_t   tin_box, sin_box;
  logic   tv  [TableDepth+1];
  box_t   tb  [TableDepth+1];
  hits_t  th  [TableDepth+1];
  logic   sv  [StageDepth+1];
  box_t   sb  [StageDepth+1];
  logic   accept;

  assign in_box = '{x: in_data_i.box_x, y: in_data_i.box_y, w: in_data_i.box_w,
                    h: in_data_i.box_h, kind: in_data_i.tag_kind,
                    idx: in_data_i.tag_index};
  assign accept = in_valid_i && in_ready_o;

  // Table chain: cell 0 takes new boxes; the tail feeds back to rotate.
  // Valid entries sit packed at the head end, the oldest in the highest cell.
  // Only the tail cell compares, so each box is checked as it passes.
  assign tv[0] = tin_valid;
  assign tb[0] = tin_box;
  assign th[0] = '0;
  for (genvar g = 0; g < TableDepth; g++) begin : g_tab
    hbct_cell #(.Colors(Colors)) u_cell (
      .clk_i, .rst_ni, .clear_i(clr), .shift_i(tshift), .valid_i(tv[g]),
      .box_i(tb[g]), .query_i(query_q),
      .acc_en_i((state_q == StScan) && (g == TableDepth - 1)), .hits_i(th[g]),
      .valid_o(tv[g+1]), .box_o(tb[g+1]), .hits_o(th[g+1])
    );
  end

  // Staging chain, same cells, no compare
  assign sv[0] = sin_valid;
  assign sb[0] = sin_box;
  for (genvar g = 0; g < StageDepth; g++) begin : g_stg
    hbct_cell #(.Colors(Colors)) u_cell (
      .clk_i, .rst_ni, .clear_i(clr), .shift_i(sshift), .valid_i(sv[g]),
      .box_i(sb[g]), .query_i(query_q), .acc_en_i(1'b0), .hits_i('0),
      .valid_o(sv[g+1]), .box_o(sb[g+1]), .hits_o()
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_data_i.action == ActQuery) state_d = StScan;
          else if (in_data_i.action == ActCommit) state_d = StCommit;
          else state_d = StOut;
        end
      end
      StScan:   if (cnt_q == CW'(TableDepth - 1)) state_d = StOut;
      StCommit: if (cnt_q == CW'(StageDepth - 1)) state_d = StOut;
      StOut:    if (out_ready_i) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Datapath control.
  // Clear: drop every valid bit in both chains at once.
  // Add: shift the table only if it is not full, else set overflow; the new box enters cell 0 and
  // all valid entries move one towards the tail, so entries stay ordered.
  // Scan: rotate the table once; the tail cell folds hits of each box.
  // Commit: shift staging once per step; staged boxes reach the tail in order.
  always_comb begin
    fill_d = fill_q; sfill_d = sfill_q; ovf_d = ovf_q; cnt_d = '0;
    hits_d = hits_q;
    tshift = 1'b0; sshift = 1'b0; clr = 1'b0;
    tin_valid = 1'b0; tin_box = in_box;
    sin_valid = 1'b0; sin_box = in_box;
    unique case (state_q)
      StIdle: begin
        hits_d = '0;
        if (accept) begin
          case (in_data_i.action)
            ActClear: begin
              fill_d = '0; sfill_d = '0; ovf_d = 1'b0;
              clr = 1'b1;
            end
            ActAdd: begin
              if (fill_q < TW'(TableDepth)) begin
                tshift = 1'b1; tin_valid = 1'b1; fill_d = fill_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            ActStage: begin
              if (sfill_q < SW'(StageDepth)) begin
                sshift = 1'b1; sin_valid = 1'b1; sfill_d = sfill_q + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      StScan: begin
        cnt_d = cnt_q + 1'b1;
        tshift = 1'b1; tin_valid = tv[TableDepth]; tin_box = tb[TableDepth];
        hits_d.rect  = hits_q.rect  | th[TableDepth].rect;
        hits_d.tlow  = hits_q.tlow  | th[TableDepth].tlow;
        hits_d.thigh = hits_q.thigh | th[TableDepth].thigh;
        hits_d.spr   = hits_q.spr   | th[TableDepth].spr;
      end
      StCommit: begin
        cnt_d = cnt_q + 1'b1;
        sshift = 1'b1;
        if (sv[StageDepth]) begin
          if (fill_q < TW'(TableDepth)) begin
            tshift = 1'b1; tin_valid = 1'b1; tin_box = sb[StageDepth];
            fill_d = fill_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
        end
        sfill_d = '0;
      end
      StOut: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= '0;
      sfill_q <= '0;
      ovf_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      sfill_q <= sfill_d;
      ovf_q   <= ovf_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hits_q <= hits_d;
    if (accept) begin
      cmd_q   <= in_data_i;
      query_q <= in_box;
    end
  end

  // Outputs
  always_comb begin
    in_ready_o  = (state_q == StIdle);
    out_valid_o = (state_q == StOut);
    out_data_o  = '0;
    if (cmd_q.action == ActQuery) begin
      out_data_o.rect_hits      = hits_q.rect;
      out_data_o.text_hits_low  = hits_q.tlow;
      out_data_o.text_hits_high = hits_q.thigh;
      out_data_o.sprite_hits    = hits_q.spr;
    end
    out_data_o.stored_count = 9'(fill_q);
    out_data_o.overflow     = ovf_q;
  end

  // Checks
  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= TW'(TableDepth)) else $error("table fill beyond depth");
  a_sfill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sfill_q <= SW'(StageDepth)) else $error("stage fill beyond depth");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");

endmodule

// ===== sv/hbct_cell.sv =====
// One cell of the box chain: holds a box and its valid bit, compares it with
// the query and folds its tag into the hit masks. Depends on hbct_pkg.
module hbct_cell import hbct_pkg::*; #(
  parameter int Colors = ColorsDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  clear_i,
  input  logic  shift_i,
  input  logic  valid_i,
  input  box_t  box_i,
  input  box_t  query_i,
  input  logic  acc_en_i,
  input  hits_t hits_i,
  output logic  valid_o,
  output box_t  box_o,
  output hits_t hits_o
);

  logic valid_q;
  box_t box_q;
  logic hit;
  logic signed [16:0] ox, oy;

  // Drop the box on a clear, else take the neighbour's box on a shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clear_i) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      box_q <= box_i;
    end
  end

  // Strict overlap: -Qw < Qx-Sx < Sw, likewise in y
  assign ox = 17'(signed'(query_i.x)) - 17'(signed'(box_q.x));
  assign oy = 17'(signed'(query_i.y)) - 17'(signed'(box_q.y));
  assign hit = valid_q && acc_en_i &&
               (-17'(signed'(query_i.w)) < ox) && (ox < 17'(signed'(box_q.w))) &&
               (-17'(signed'(query_i.h)) < oy) && (oy < 17'(signed'(box_q.h)));

  // Fold the tag of a hit box into the masks
  always_comb begin
    hits_o = hits_i;
    if (hit) begin
      case (box_q.kind)
        KindRect: begin
          if (32'(box_q.idx) < 32'(Colors) && box_q.idx < 7'd16) begin
            hits_o.rect[box_q.idx[3:0]] = 1'b1;
          end
        end
        KindGlyph: begin
          if (box_q.idx >= GlyphFirst && box_q.idx < GlyphSplit) begin
            hits_o.tlow[6'(box_q.idx - GlyphFirst)] = 1'b1;
          end else if (box_q.idx >= GlyphSplit && box_q.idx <= GlyphLast) begin
            hits_o.thigh[5'(box_q.idx - GlyphSplit)] = 1'b1;
          end
        end
        KindSprite: begin
          if (box_q.idx >= LetterFirst && box_q.idx <= LetterLast) begin
            hits_o.spr[5'(box_q.idx - LetterFirst)] = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign valid_o = valid_q;
  assign box_o   = box_q;

endmodule
